[sv/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SACL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sacl assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SACL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sacl assertion failed");

`endif

[sv/sacl_pkg.sv]
package sacl_pkg;

	localparam int ADDR_W     = 64;
	localparam int TOTAL_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int SB_W       = 3;
	localparam int WAYS_W     = 4;
	localparam int BB_W       = 6;

	localparam logic [SB_W-1:0]   SET_BITS_RST   = 3'd4;
	localparam logic [WAYS_W-1:0] WAYS_RST       = 4'd1;
	localparam logic [BB_W-1:0]   BLOCK_BITS_RST = 6'd4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS   = 2'd0,
		CFG_WAYS       = 2'd1,
		CFG_BLOCK_BITS = 2'd2
	} cfg_index_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_LOOKUP
	} ctrl_state_t;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] address;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         hits_now;
		logic               misses_now;
		logic               evictions_now;
		logic [TOTAL_W-1:0] total_hits;
		logic [TOTAL_W-1:0] total_misses;
		logic [TOTAL_W-1:0] total_evictions;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

endpackage

[sv/sacl_ctrl.sv]
module sacl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output sacl_pkg::dp_cmd_t cmd
);
	import sacl_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs: accept in idle, commit once the result register frees up
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_LOOKUP: begin
				cmd.commit = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// Load on commit, drop once taken
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[sv/sacl_dp.sv]
module sacl_dp #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  sacl_pkg::in_item_t                 in_data,
	input  sacl_pkg::dp_cmd_t                  cmd,
	output sacl_pkg::out_item_t                out_data
);
	import sacl_pkg::*;

	localparam int SETS   = 1 << MAX_SET_BITS;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W = WAY_W;
	localparam int CNT_W  = $clog2(MAX_WAYS + 1);
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

	// Configuration registers
	logic [SB_W-1:0]   set_bits_q;
	logic [WAYS_W-1:0] ways_q;
	logic [BB_W-1:0]   block_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= SET_BITS_RST;
			ways_q       <= WAYS_RST;
			block_bits_q <= BLOCK_BITS_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_SET_BITS:   set_bits_q   <= cfg_data[SB_W-1:0];
				CFG_WAYS:       ways_q       <= cfg_data[WAYS_W-1:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data[BB_W-1:0];
				default:        set_bits_q   <= set_bits_q;
			endcase
		end
	end

	// Split the address into set index and tag
	logic [SB_W-1:0]         sb_eff;
	logic [6:0]              tag_shift;
	logic [ADDR_W-1:0]       above;
	logic [MAX_SET_BITS-1:0] set_mask;
	logic [MAX_SET_BITS-1:0] set_idx;
	logic [ADDR_W-1:0]       tag_in;

	always_comb begin
		sb_eff    = (32'(set_bits_q) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : set_bits_q;
		tag_shift = {4'b0, sb_eff} + {1'b0, block_bits_q};
		above     = in_data.address >> block_bits_q;
		set_mask  = ~({MAX_SET_BITS{1'b1}} << sb_eff);
		set_idx   = above[MAX_SET_BITS-1:0] & set_mask;
		tag_in    = tag_shift[6] ? '0 : (in_data.address >> tag_shift[5:0]);
	end

	// Set storage, one row per set
	logic [MAX_WAYS-1:0]                 valid_mem [SETS];
	logic [MAX_WAYS-1:0][ADDR_W-1:0]     tag_mem   [SETS];
	logic [MAX_WAYS-1:0][RANK_W-1:0]     rank_mem  [SETS];
	logic [SETS-1:0]                     row_written_q;

	logic                                op_s1;
	logic [MAX_SET_BITS-1:0]             set_s1;
	logic [ADDR_W-1:0]                   tag_s1;
	logic                                row_ok_s1;
	logic [MAX_WAYS-1:0]                 rd_valid_s1;
	logic [MAX_WAYS-1:0][ADDR_W-1:0]     rd_tag_s1;
	logic [MAX_WAYS-1:0][RANK_W-1:0]     rd_rank_s1;

	logic [MAX_WAYS-1:0]                 new_valid;
	logic [MAX_WAYS-1:0][ADDR_W-1:0]     new_tag;
	logic [MAX_WAYS-1:0][RANK_W-1:0]     new_rank;

	// Read on capture, write back on commit
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1       <= in_data.op;
			set_s1      <= set_idx;
			tag_s1      <= tag_in;
			row_ok_s1   <= row_written_q[set_idx];
			rd_valid_s1 <= valid_mem[set_idx];
			rd_tag_s1   <= tag_mem[set_idx];
			rd_rank_s1  <= rank_mem[set_idx];
		end
		if (cmd.commit) begin
			valid_mem[set_s1] <= new_valid;
			tag_mem[set_s1]   <= new_tag;
			rank_mem[set_s1]  <= new_rank;
		end
	end

	// A row never written reads as all lines invalid, rank zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_written_q <= '0;
		end else if (cmd.commit) begin
			row_written_q[set_s1] <= 1'b1;
		end
	end

	// Lookup: compare all active ways, pick hit, free or LRU way
	logic [CNT_W-1:0]                ways_eff;
	logic [MAX_WAYS-1:0]             active;
	logic [MAX_WAYS-1:0]             cur_valid;
	logic [MAX_WAYS-1:0][RANK_W-1:0] cur_rank;
	logic                            hit;
	logic                            any_free;
	logic [WAY_W-1:0]                hit_way;
	logic [WAY_W-1:0]                free_way;
	logic [WAY_W-1:0]                victim;
	logic [RANK_W-1:0]               best_rank;
	logic [WAY_W-1:0]                sel_way;
	logic                            fresh;
	logic [RANK_W-1:0]               old_rank;

	always_comb begin
		if (ways_q == '0) begin
			ways_eff = CNT_W'(1);
		end else if (32'(ways_q) > MAX_WAYS) begin
			ways_eff = CNT_W'(MAX_WAYS);
		end else begin
			ways_eff = CNT_W'(ways_q);
		end
		cur_valid = row_ok_s1 ? rd_valid_s1 : '0;
		cur_rank  = row_ok_s1 ? rd_rank_s1 : '0;
		hit       = 1'b0;
		any_free  = 1'b0;
		hit_way   = '0;
		free_way  = '0;
		for (int j = MAX_WAYS - 1; j >= 0; j--) begin
			active[j] = (j < int'(ways_eff));
			if (active[j] && cur_valid[j] && (rd_tag_s1[j] == tag_s1)) begin
				hit     = 1'b1;
				hit_way = WAY_W'(j);
			end
			if (active[j] && !cur_valid[j]) begin
				any_free = 1'b1;
				free_way = WAY_W'(j);
			end
		end
	end

	// Oldest active line, lowest way on a tie
	always_comb begin
		victim    = '0;
		best_rank = cur_rank[0];
		for (int j = 1; j < MAX_WAYS; j++) begin
			if (active[j] && (cur_rank[j] > best_rank)) begin
				best_rank = cur_rank[j];
				victim    = WAY_W'(j);
			end
		end
	end

	// Make the chosen way most recent, age the younger lines
	always_comb begin
		fresh     = !hit && any_free;
		sel_way   = hit ? hit_way : (any_free ? free_way : victim);
		old_rank  = cur_rank[sel_way];
		new_valid = cur_valid;
		new_tag   = rd_tag_s1;
		new_rank  = cur_rank;
		for (int j = 0; j < MAX_WAYS; j++) begin
			if (active[j]) begin
				if (WAY_W'(j) == sel_way) begin
					new_rank[j]  = '0;
					new_valid[j] = 1'b1;
					if (!hit) begin
						new_tag[j] = tag_s1;
					end
				end else if (cur_valid[j] && (fresh || (cur_rank[j] < old_rank))
						&& (cur_rank[j] != RANK_MAX)) begin
					new_rank[j] = cur_rank[j] + RANK_W'(1);
				end
			end
		end
	end

	// Per-item counts; a modify adds one sure hit on the same line
	logic [1:0]         hits_now;
	logic               misses_now;
	logic               evictions_now;
	logic [TOTAL_W:0]   hit_sum;
	logic [TOTAL_W:0]   miss_sum;
	logic [TOTAL_W:0]   evict_sum;
	logic [TOTAL_W-1:0] hit_total_q;
	logic [TOTAL_W-1:0] miss_total_q;
	logic [TOTAL_W-1:0] evict_total_q;
	logic [TOTAL_W-1:0] hit_total_nxt;
	logic [TOTAL_W-1:0] miss_total_nxt;
	logic [TOTAL_W-1:0] evict_total_nxt;

	always_comb begin
		hits_now        = {1'b0, hit} + {1'b0, op_s1};
		misses_now      = !hit;
		evictions_now   = !hit && !any_free;
		hit_sum         = {1'b0, hit_total_q} + (TOTAL_W + 1)'(hits_now);
		miss_sum        = {1'b0, miss_total_q} + (TOTAL_W + 1)'(misses_now);
		evict_sum       = {1'b0, evict_total_q} + (TOTAL_W + 1)'(evictions_now);
		hit_total_nxt   = hit_sum[TOTAL_W] ? '1 : hit_sum[TOTAL_W-1:0];
		miss_total_nxt  = miss_sum[TOTAL_W] ? '1 : miss_sum[TOTAL_W-1:0];
		evict_total_nxt = evict_sum[TOTAL_W] ? '1 : evict_sum[TOTAL_W-1:0];
	end

	// Saturating totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_total_q   <= '0;
			miss_total_q  <= '0;
			evict_total_q <= '0;
		end else if (cmd.commit) begin
			hit_total_q   <= hit_total_nxt;
			miss_total_q  <= miss_total_nxt;
			evict_total_q <= evict_total_nxt;
		end
	end

	// Result register
	out_item_t out_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.hits_now        <= hits_now;
			out_q.misses_now      <= misses_now;
			out_q.evictions_now   <= evictions_now;
			out_q.total_hits      <= hit_total_nxt;
			out_q.total_misses    <= miss_total_nxt;
			out_q.total_evictions <= evict_total_nxt;
		end
	end

	assign out_data = out_q;

endmodule

[sv/set_assoc_cache_lru_model.sv]
// Channel | Direction | Handshake             | Payload
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
// in      | in        | in_valid / in_ready   | in_data (op, address)
// out     | out       | out_valid / out_ready | out_data (counts and totals)
// Each item passes two steps: capture reads its set row from the set memory into the
// lookup registers; commit compares all ways, writes the row back and loads the result register.
// The next item is taken while a result waits; the lookup holds if the result is not taken.
// After reset every set reads as empty at once through per-set written flags; no clearing pass.
// Configuration writes are always taken.
module set_assoc_cache_lru_model #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  sacl_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output sacl_pkg::out_item_t             out_data
);
	import sacl_pkg::*;

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	sacl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	sacl_dp #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_data  (out_data)
	);

endmodule

[sv/sacl_checker.sv]
`include "assert_macros.svh"

module sacl_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input sacl_pkg::out_item_t out_data
);
	import sacl_pkg::*;

	// Hold a stalled result
	`SACL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// One item at a time: no accept right after an accept
	`SACL_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
	// An eviction only comes with a miss
	`SACL_ASSERT_NOW(a_evict_needs_miss, out_valid && out_data.evictions_now,
		out_data.misses_now)
	// Every item makes at least one access, at most two hits
	`SACL_ASSERT_NOW(a_access_count, out_valid,
		(out_data.hits_now != 2'd0 || out_data.misses_now) && out_data.hits_now != 2'd3)

endmodule

bind set_assoc_cache_lru_model sacl_checker u_sacl_checker (.*);
